>>> rtl/zba_pkg.sv
package zba_pkg;

  // command codes on cmd_i
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_FIRST_DATA_ZONE = 1'b0;
  localparam logic REG_ZONE_COUNT      = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_WASFREE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_AL_SUM,
    S_AL_MOD,
    S_FR_MOD
  } state_e;

endpackage

>>> rtl/zone_bitmap_allocator_core.sv
// channel   | signals                                  | handshake
// ----------+------------------------------------------+----------------------------------
// command   | cmd_i, zone_number_i                     | accepted when start && !busy
// result    | status_o, allocated_zone_o               | done_o strobe, one cycle, no stall
// config    | psel, penable, pwrite, paddr, pwdata,    | APB write in access cycle,
//           | prdata, pready                           | pready tied high
//
// steps: allocate does summary read, bitmap word read, write back; free does
//   word and summary read together, then write back; no space or bad range
//   is answered from idle; the result strobe comes in the cycle after the last
//   step, and a new item may be accepted in that same cycle
// the steps follow from the registered read data of the two memories
// reset: a clearing pass writes every bitmap word and summary word, one per
//   cycle, over MAP_WORDS bitmap words (2048 at default size), busy stays high meanwhile
// the receiver cannot stall, results are never held
module zone_bitmap_allocator_core
  import zba_pkg::*;
#(
  parameter int MAP_BLOCKS   = 8,
  parameter int BITS_PER_MAP = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [15:0] zone_number_i,
  // result channel
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] allocated_zone_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TOTAL_BITS = MAP_BLOCKS * BITS_PER_MAP;
  localparam int MAP_WORDS  = (TOTAL_BITS + 31) / 32;
  localparam int SUM_WORDS  = (MAP_WORDS + 31) / 32;
  localparam int WA_W       = $clog2(MAP_WORDS);
  localparam int BIT_W      = WA_W + 5;
  localparam int SA_W       = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] first_data_zone_q;
  logic [15:0] zone_count_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_data_zone_q <= 16'd1;
      zone_count_q      <= 16'd0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_FIRST_DATA_ZONE) begin
        first_data_zone_q <= pwdata[15:0];
      end else begin
        zone_count_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ZONE_COUNT) ? {16'd0, zone_count_q}
                                               : {16'd0, first_data_zone_q};

  // ---------------------------------------------------------------------------
  // memories: bitmap words, and a summary with one bit per full bitmap word
  // ---------------------------------------------------------------------------
  logic [31:0]     bm_mem [MAP_WORDS];
  logic            bm_we, bm_re;
  logic [WA_W-1:0] bm_waddr, bm_raddr;
  logic [31:0]     bm_wdata, bm_rdata_q;

  logic [31:0]     sm_mem [SUM_WORDS];
  logic            sm_we, sm_re;
  logic [SA_W-1:0] sm_waddr, sm_raddr;
  logic [31:0]     sm_wdata, sm_rdata_q;

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rdata_q <= bm_mem[bm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      sm_mem[sm_waddr] <= sm_wdata;
    end
    if (sm_re) begin
      sm_rdata_q <= sm_mem[sm_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [WA_W-1:0]  clr_q, clr_d;
  // top level summary: bit s set when summary word s is all ones
  logic [SUM_WORDS-1:0] top_q, top_d;

  logic [SA_W-1:0]  s_q, s_d;       // summary word of the item
  logic [4:0]       j_q, j_d;       // bit inside the summary word
  logic [WA_W-1:0]  w_q, w_d;       // bitmap word
  logic [4:0]       pos_q, pos_d;   // bit inside the bitmap word

  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [15:0]      zone_q, zone_d;

  // first clear bit at each level
  logic             top_found, sw_found, wd_found;
  logic [SA_W-1:0]  top_idx;
  logic [4:0]       sw_idx, wd_idx;

  zba_first_zero #(.W(SUM_WORDS)) u_top_find (
    .vec_i   (top_q),
    .found_o (top_found),
    .idx_o   (top_idx)
  );

  zba_first_zero #(.W(32)) u_sum_find (
    .vec_i   (sm_rdata_q),
    .found_o (sw_found),
    .idx_o   (sw_idx)
  );

  zba_first_zero #(.W(32)) u_word_find (
    .vec_i   (bm_rdata_q),
    .found_o (wd_found),
    .idx_o   (wd_idx)
  );

  // free: range check and bit position
  logic [17:0]      fr_bfull;
  logic             fr_bad;
  logic [BIT_W-1:0] fr_bit;
  logic [WA_W-1:0]  fr_word;
  logic [SA_W-1:0]  fr_sidx;

  assign fr_bfull = {2'd0, zone_number_i} - {2'd0, first_data_zone_q} + 18'd1;
  assign fr_bad   = (zone_number_i < first_data_zone_q) ||
                    (zone_number_i >= zone_count_q) ||
                    (fr_bfull >= 18'(TOTAL_BITS));
  assign fr_bit   = fr_bfull[BIT_W-1:0];
  assign fr_word  = fr_bit[BIT_W-1:5];
  assign fr_sidx  = SA_W'(fr_word >> 5);

  // allocate: word address from summary position, new word and summary values
  logic [SA_W+4:0]  al_wcat;
  logic [WA_W-1:0]  al_word;
  logic [31:0]      al_new_word, al_new_sum;
  logic [BIT_W-1:0] al_bit;
  logic [17:0]      al_zone;

  assign al_wcat     = {s_q, sw_idx};
  assign al_word     = al_wcat[WA_W-1:0];
  assign al_new_word = bm_rdata_q | (32'd1 << wd_idx);
  assign al_new_sum  = sm_rdata_q | (32'd1 << j_q);
  assign al_bit      = {w_q, wd_idx};
  // bit zero stays set, so the granted bit is at least one and nothing wraps
  assign al_zone     = 18'(al_bit) + {2'd0, first_data_zone_q} - 18'd1;

  // summary padding during the clearing pass: words past the map count as full
  logic [31:0] sum_init;
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      sum_init[j] = (int'(clr_q) * 32 + j) >= MAP_WORDS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      top_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      top_q   <= top_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    j_q      <= j_d;
    w_q      <= w_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    zone_q   <= zone_d;
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    top_d    = top_q;
    s_d      = s_q;
    j_d      = j_q;
    w_d      = w_q;
    pos_d    = pos_q;
    done_d   = 1'b0;
    status_d = status_q;
    zone_d   = zone_q;

    bm_we    = 1'b0;
    bm_waddr = w_q;
    bm_wdata = al_new_word;
    bm_re    = 1'b0;
    bm_raddr = fr_word;
    sm_we    = 1'b0;
    sm_waddr = s_q;
    sm_wdata = al_new_sum;
    sm_re    = 1'b0;
    sm_raddr = fr_sidx;

    unique case (state_q)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = (clr_q == '0) ? 32'd1 : 32'd0;
        if (int'(clr_q) < SUM_WORDS) begin
          sm_we    = 1'b1;
          sm_waddr = clr_q[SA_W-1:0];
          sm_wdata = sum_init;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == WA_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_ALLOC) begin
            if (!top_found) begin
              // every word full
              done_d   = 1'b1;
              status_d = ST_NOSPACE;
              zone_d   = 16'd0;
            end else begin
              sm_re    = 1'b1;
              sm_raddr = top_idx;
              s_d      = top_idx;
              state_d  = S_AL_SUM;
            end
          end else begin
            if (fr_bad) begin
              done_d   = 1'b1;
              status_d = ST_RANGE;
              zone_d   = 16'd0;
            end else begin
              // word and its summary word are read side by side
              bm_re   = 1'b1;
              sm_re   = 1'b1;
              s_d     = fr_sidx;
              j_d     = fr_word[4:0];
              w_d     = fr_word;
              pos_d   = fr_bit[4:0];
              state_d = S_FR_MOD;
            end
          end
        end
      end

      S_AL_SUM: begin
        bm_re    = 1'b1;
        bm_raddr = al_word;
        w_d      = al_word;
        j_d      = sw_idx;
        state_d  = S_AL_MOD;
      end

      S_AL_MOD: begin
        bm_we = 1'b1;
        if (al_new_word == '1) begin
          sm_we = 1'b1;
          if (al_new_sum == '1) begin
            top_d[s_q] = 1'b1;
          end
        end
        done_d = 1'b1;
        // bit stays set even when the zone lies beyond the device
        if (al_zone >= {2'd0, zone_count_q}) begin
          status_d = ST_NOSPACE;
          zone_d   = 16'd0;
        end else begin
          status_d = ST_OK;
          zone_d   = al_zone[15:0];
        end
        state_d = S_IDLE;
      end

      S_FR_MOD: begin
        done_d = 1'b1;
        zone_d = 16'd0;
        if (!bm_rdata_q[pos_q]) begin
          status_d = ST_WASFREE;
        end else begin
          status_d   = ST_OK;
          bm_we      = 1'b1;
          bm_wdata   = bm_rdata_q & ~(32'd1 << pos_q);
          sm_we      = 1'b1;
          sm_wdata   = sm_rdata_q & ~(32'd1 << j_q);
          top_d[s_q] = 1'b0;
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign allocated_zone_o = zone_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // summary said this summary word has a non-full bitmap word
  a_sum_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AL_SUM) |-> sw_found)
    else $error("summary word read as full during allocate");

  // summary said this bitmap word has a clear bit
  a_word_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AL_MOD) |-> wd_found)
    else $error("bitmap word read as full during allocate");

  // a zone is only granted with status ok
  a_zone_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (allocated_zone_o == 16'd0))
    else $error("zone granted with failing status");

  // a result follows an accepted item or a finishing step
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past((state_q == S_AL_MOD) || (state_q == S_FR_MOD) ||
                     (start && !busy)))
    else $error("result without a command");

endmodule

>>> rtl/zba_first_zero.sv
module zba_first_zero #(
  parameter int W = 32
) (
  input  logic [W-1:0]                 vec_i,
  output logic                         found_o,
  output logic [((W > 1) ? $clog2(W) : 1)-1:0] idx_o
);

  localparam int IW = (W > 1) ? $clog2(W) : 1;

  // lowest clear bit wins
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (!vec_i[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule

>>> bench/tb_zone_bitmap_allocator_core.sv
`timescale 1ns / 100ps

module tb_zone_bitmap_allocator_core;
  import zba_pkg::*;

  // bitmap geometry at the default parameters
  localparam int unsigned MAP_BITS  = 8 * 8192;
  localparam int unsigned MAP_WORDS = MAP_BITS / 32;
  // cycles without any handshake before the run is abandoned; the clearing
  // pass after reset (one bitmap word per cycle) is the longest quiet stretch
  localparam int STALL_LIMIT = 5 * MAP_WORDS + 1000;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    status_e     status;
    logic [15:0] zone;
  } zone_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = CMD_ALLOC;
  logic [15:0] zone_number_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] allocated_zone_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  zone_bitmap_allocator_core dut (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor state: its own copy of the free-zone bitmap and registers
  // ---------------------------------------------------------------------
  logic [31:0]  zone_map [MAP_WORDS];
  int unsigned  first_open_word;     // every word below this one is full
  logic [15:0]  cfg_first_data_zone;
  logic [15:0]  cfg_zone_count;

  zone_result_t expected_results [$];
  logic [15:0]  granted_zones [$];   // zones handed out under the current mapping
  logic [15:0]  last_freed_zone;

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  int  reg_settings = 0;
  int  stall_cycles = 0;
  bit  gaps_enabled = 1'b1;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch @%0t: %s", $time, msg);
  endtask

  // first-fit allocate or free, exactly as the block should do it
  task automatic predict_zone_op(input logic op, input logic [15:0] zn,
                                 output zone_result_t res);
    int unsigned w;
    int unsigned bit_idx;
    int unsigned zone;
    res.status = ST_OK;
    res.zone   = '0;
    if (op == CMD_ALLOC) begin
      w = first_open_word;
      while (w < MAP_WORDS && zone_map[w] == '1) w++;
      first_open_word = w;
      if (w == MAP_WORDS) begin
        // bitmap full, nothing changes
        res.status = ST_NOSPACE;
      end else begin
        bit_idx = w * 32;
        while (zone_map[w][bit_idx % 32]) bit_idx++;
        // the bit is taken even when its zone lies beyond the device
        zone_map[w][bit_idx % 32] = 1'b1;
        zone = bit_idx + 32'(cfg_first_data_zone) - 1;
        if (zone >= 32'(cfg_zone_count)) res.status = ST_NOSPACE;
        else res.zone = zone[15:0];
      end
    end else begin
      if (zn < cfg_first_data_zone || zn >= cfg_zone_count) begin
        res.status = ST_RANGE;
      end else begin
        bit_idx = 32'(zn) - 32'(cfg_first_data_zone) + 1;
        if (bit_idx >= MAP_BITS) begin
          res.status = ST_RANGE;
        end else if (!zone_map[bit_idx / 32][bit_idx % 32]) begin
          res.status = ST_WASFREE;
        end else begin
          zone_map[bit_idx / 32][bit_idx % 32] = 1'b0;
          if (bit_idx / 32 < first_open_word) first_open_word = bit_idx / 32;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // random sender idling now and then, start held low meanwhile
  task automatic idle_gap();
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // hand one item to the block and queue what it should answer
  task automatic send_item(input logic op, input logic [15:0] zn);
    zone_result_t res;
    idle_gap();
    start         <= 1'b1;
    cmd_i         <= op;
    zone_number_i <= zn;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_zone_op(op, zn, res);
    expected_results.push_back(res);
    items_sent++;
    if (op == CMD_ALLOC && res.status == ST_OK) granted_zones.push_back(res.zone);
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // apb: optional write of both registers, then read back of both;
  // psel stays high across the transfers so it never toggles within a step
  task automatic zone_regs_access(input bit do_write, input logic [15:0] fdz,
                                  input logic [15:0] zc);
    logic [15:0] want;
    int i;
    for (i = 0; i < 4; i++) begin
      if (i < 2 && !do_write) continue;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (i < 2);
      paddr   <= {(i[0] ? REG_ZONE_COUNT : REG_FIRST_DATA_ZONE), 2'b00};
      // upper data bits are junk, the registers are 16 bits wide
      pwdata  <= {16'($urandom), (i[0] ? zc : fdz)};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      if (i == 0) cfg_first_data_zone = fdz;
      else if (i == 1) cfg_zone_count = zc;
      else begin
        want = i[0] ? cfg_zone_count : cfg_first_data_zone;
        if (prdata !== {16'h0000, want})
          report_mismatch($sformatf("register %0d read %h, want %h", i[0], prdata, want));
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (do_write) reg_settings++;
  endtask

  // new zone mapping: only once the block has gone quiet
  task automatic set_zone_map(input logic [15:0] fdz, input logic [15:0] zc);
    drain_results();
    zone_regs_access(1'b1, fdz, zc);
    granted_zones.delete();
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // register defaults, and a device of zero zones
  task automatic test_reset_state();
    zone_regs_access(1'b0, '0, '0);
    send_item(CMD_ALLOC, 16'h0000);  // zone 1 is beyond a zero-zone device
    send_item(CMD_FREE, 16'h0001);   // so is every free
    send_item(CMD_FREE, 16'hffff);
  endtask

  task automatic test_directed_cases();
    set_zone_map(16'd1, 16'hffff);
    send_item(CMD_ALLOC, 16'hffff);  // zone number ignored on allocate
    send_item(CMD_ALLOC, 16'h0000);
    send_item(CMD_FREE, 16'd2);
    send_item(CMD_FREE, 16'd2);      // double free
    send_item(CMD_FREE, 16'd1);      // bit swallowed under the empty device
    send_item(CMD_FREE, 16'd0);      // below the first data zone
    send_item(CMD_FREE, 16'hffff);   // at zone count
    send_item(CMD_FREE, 16'hfffe);   // last valid zone, never taken
    send_item(CMD_ALLOC, 16'h5a5a);
    send_item(CMD_ALLOC, 16'ha5a5);
    // first data zone of zero: bit k maps to zone k-1
    set_zone_map(16'd0, 16'hffff);
    send_item(CMD_ALLOC, 16'h0000);
    send_item(CMD_FREE, 16'd0);
    send_item(CMD_ALLOC, 16'h0000);  // grants zone 0
    send_item(CMD_FREE, 16'd3);
    // mapping pushed to the top: every allocate lands beyond the device
    set_zone_map(16'hffff, 16'hffff);
    send_item(CMD_ALLOC, 16'h0000);
    send_item(CMD_FREE, 16'hffff);
    send_item(CMD_FREE, 16'hfffe);
    set_zone_map(16'h8000, 16'h8010);
    send_item(CMD_ALLOC, 16'h0000);
    send_item(CMD_FREE, 16'h8000);
    send_item(CMD_FREE, 16'h8001);
    send_item(CMD_FREE, 16'h800f);
    send_item(CMD_FREE, 16'h8010);
  endtask

  // mostly allocate/free traffic on zones that were really granted,
  // with double frees and arbitrary zone numbers mixed in
  task automatic random_phase(input logic [15:0] fdz, input logic [15:0] zc, input int n);
    int k;
    int pick;
    logic [15:0] zn;
    set_zone_map(fdz, zc);
    last_freed_zone = fdz;
    for (k = 0; k < n; k++) begin
      if (k % 50 == 0) gaps_enabled = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 39) == 0) drain_results();
      if ($urandom_range(0, 1) == 0) begin
        send_item(CMD_ALLOC, 16'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45 && granted_zones.size() != 0) begin
          pick = $urandom_range(0, granted_zones.size() - 1);
          zn = granted_zones[pick];
          granted_zones.delete(pick);
        end else if (pick < 60) begin
          zn = last_freed_zone;
        end else if (pick < 80 && zc > fdz) begin
          zn = 16'($urandom_range(fdz, zc - 1));
        end else begin
          zn = 16'($urandom);
        end
        last_freed_zone = zn;
        send_item(CMD_FREE, zn);
      end
    end
  endtask

  task automatic test_random_traffic();
    random_phase(16'd1, 16'hffff, 200);
    random_phase(16'd1, 16'd400, 180);   // lowest clear bit runs past the device
    random_phase(16'd0, 16'hffff, 160);
    random_phase(16'($urandom_range(2, 30000)), 16'($urandom_range(30000, 65535)), 180);
    random_phase(16'hffff, 16'hffff, 60);
    random_phase(16'($urandom_range(100, 65535)), 16'd0, 40);
    random_phase(16'd1, 16'hffff, 180);
  endtask

  // a run of allocates across several words, holes punched and refilled;
  // this is the tail of the run, so once the new mapping is set the sender never idles
  task automatic test_fill_and_drain();
    int k;
    random_phase(16'd1, 16'hffff, 60);
    gaps_enabled = 1'b0;
    set_zone_map(16'd1, 16'hffff);
    repeat (30) send_item(CMD_ALLOC, 16'($urandom));
    for (k = 0; k < 40; k++) send_item(CMD_FREE, 16'($urandom_range(1, 65534)));
    send_item(CMD_FREE, 16'hffff);     // last bit: beyond the device
    repeat (45) send_item(CMD_ALLOC, 16'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // result checking: done_o is a one-cycle strobe, no back-pressure
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    zone_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (!$isunknown(status_o)) status_seen[status_o]++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d zone %0d",
                                  status_o, allocated_zone_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                    results_seen, status_o, want.status));
        if (allocated_zone_o !== want.zone)
          report_mismatch($sformatf("result %0d: zone %0d, want %0d",
                                    results_seen, allocated_zone_o, want.zone));
      end
    end
  end

  // watchdog: any item, result or register transfer counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o === 1'b1 || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned w;
    for (w = 0; w < MAP_WORDS; w++) zone_map[w] = '0;
    zone_map[0]         = 32'h0000_0001;  // bit 0 is reserved
    first_open_word     = 0;
    cfg_first_data_zone = 16'd1;
    cfg_zone_count      = 16'd0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // busy covers the clearing pass over the bitmap
    do @(posedge clk_i); while (busy !== 1'b0);

    test_reset_state();
    test_directed_cases();
    test_random_traffic();
    test_fill_and_drain();

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("summary: %0d items, %0d results, %0d register settings",
             items_sent, results_seen, reg_settings);
    $display("summary: status ok %0d, no space %0d, out of range %0d, already free %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/zba_pkg.sv
rtl/zba_first_zero.sv
rtl/zone_bitmap_allocator_core.sv
bench/tb_zone_bitmap_allocator_core.sv
